/* rtl/sbip_pkg.sv */
// ============================================================================
// sbip_pkg
// Shared command and status types for the shuffle bag index picker.
// ============================================================================
package sbip_pkg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the request fields
        logic clear_bag;   // new pool size: empty the bag and forget the last pick
        logic fill_init;   // restart the refill counter
        logic fill_step;   // write one refill entry
        logic set_full;    // bag count takes the pool size
        logic div_init;    // restart the modulo reduction
        logic div_step;    // one bit of the modulo reduction
        logic swap_slot;   // move the slot between zero and one
        logic take_pick;   // keep the slot entry, read the last entry
        logic commit;      // move the last entry into the slot, shrink the bag
        logic load_out;    // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic size_zero;
        logic size_changed;
        logic count_zero;
        logic fill_last;
        logic div_last;
        logic repeat_hit;
    } t_status;

    localparam int unsigned SizeW  = 9;
    localparam int unsigned WordW  = 32;
    localparam int unsigned IndexW = 8;

endpackage

/* rtl/sbip_ram.sv */
// ============================================================================
// sbip_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module sbip_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/sbip_dp.sv */
// ============================================================================
// sbip_dp
// Datapath: request registers, bag state, refill counter, bit-serial modulo
// unit, bag memory and result register.
// ============================================================================
module sbip_dp
    import sbip_pkg::*;
#(
    parameter int unsigned POOL_MAX = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [SizeW-1:0]  i_pool_size,
    input  logic [WordW-1:0]  i_random_word,
    output logic [IndexW-1:0] o_picked_index,
    output logic              o_empty_pool_error
);

    // The pool size field tops out at 511, so the bag never holds more.
    localparam int unsigned Cap   = (POOL_MAX < 511) ? POOL_MAX : 511;
    localparam int unsigned IdxW  = $clog2(Cap);
    localparam int unsigned CntW  = $clog2(Cap + 1);
    localparam int unsigned DivW  = IdxW + 1;
    localparam int unsigned BitW  = $clog2(WordW);

    logic [CntW-1:0]  r_size, r_cur, r_count;
    logic [WordW-1:0] r_word;
    logic             r_err;
    logic [IdxW-1:0]  r_fill, r_slot, r_pick, r_prev;
    logic             r_prev_valid;
    logic [BitW-1:0]  r_bit;
    logic [IndexW-1:0] r_out_idx;
    logic             r_out_err;

    logic [SizeW-1:0]  sat_size;
    logic [CntW-1:0]   cnt_m1;
    logic [DivW-1:0]   shifted, diff, count_ext;
    logic              ge;
    logic              ram_we;
    logic [IdxW-1:0]   ram_waddr, ram_wdata, ram_raddr, ram_rdata;
    logic [IdxW+IndexW-1:0] pick_ext;

    assign sat_size = (i_pool_size > SizeW'(Cap)) ? SizeW'(Cap) : i_pool_size;
    assign cnt_m1   = r_count - 1'b1;

    // One restoring step of word modulo count.
    assign count_ext = DivW'(r_count);
    assign shifted   = {r_slot, r_word[WordW-1]};
    assign ge        = (shifted >= count_ext);
    assign diff      = shifted - count_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_count      <= '0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_bag) begin
                r_cur        <= r_size;
                r_count      <= '0;
                r_prev_valid <= 1'b0;
            end
            if (i_cmd.set_full) begin
                r_count <= r_size;
            end
            if (i_cmd.commit) begin
                r_count      <= cnt_m1;
                r_prev       <= r_pick;
                r_prev_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_size <= CntW'(sat_size);
            r_word <= i_random_word;
            r_err  <= (i_pool_size == '0);
        end
        if (i_cmd.fill_init) begin
            r_fill <= '0;
        end else if (i_cmd.fill_step) begin
            r_fill <= r_fill + 1'b1;
        end
        if (i_cmd.div_init) begin
            r_slot <= '0;
            r_bit  <= '0;
        end else if (i_cmd.div_step) begin
            r_slot <= ge ? diff[IdxW-1:0] : shifted[IdxW-1:0];
            r_word <= {r_word[WordW-2:0], 1'b0};
            r_bit  <= r_bit + 1'b1;
        end else if (i_cmd.swap_slot) begin
            r_slot <= (r_slot == '0) ? IdxW'(1) : '0;
        end
        if (i_cmd.take_pick) begin
            r_pick <= ram_rdata;
        end
        if (i_cmd.load_out) begin
            r_out_idx <= r_err ? '0 : pick_ext[IndexW-1:0];
            r_out_err <= r_err;
        end
    end

    assign pick_ext = {{IndexW{1'b0}}, r_pick};

    assign ram_we    = i_cmd.fill_step || i_cmd.commit;
    assign ram_waddr = i_cmd.fill_step ? r_fill : r_slot;
    assign ram_wdata = i_cmd.fill_step ? r_fill : ram_rdata;
    assign ram_raddr = i_cmd.take_pick ? cnt_m1[IdxW-1:0] : r_slot;

    sbip_ram #(
        .WIDTH (IdxW),
        .DEPTH (Cap)
    ) u_bag (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign o_status.size_zero    = r_err;
    assign o_status.size_changed = (r_size != r_cur);
    assign o_status.count_zero   = (r_count == '0);
    assign o_status.fill_last    = ((CntW'(r_fill) + 1'b1) == r_size);
    assign o_status.div_last     = (r_bit == BitW'(WordW - 1));
    assign o_status.repeat_hit   = (r_size > CntW'(1)) && (r_count == r_size)
                                   && r_prev_valid && (ram_rdata == r_prev);

    assign o_picked_index     = r_out_idx;
    assign o_empty_pool_error = r_out_err;

endmodule

/* rtl/sbip_ctrl.sv */
// ============================================================================
// sbip_ctrl
// Controller: sequences capture, refill, modulo, bag update and result load.
// ============================================================================
module sbip_ctrl
    import sbip_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_FILL,
        S_DIV,
        S_RD_SLOT,
        S_CHK,
        S_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.size_zero) begin
                    n_state = S_DONE;
                end else if (i_status.size_changed || i_status.count_zero) begin
                    o_cmd.clear_bag = i_status.size_changed;
                    o_cmd.fill_init = 1'b1;
                    n_state         = S_FILL;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    o_cmd.set_full = 1'b1;
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_RD_SLOT;
                end
            end
            S_RD_SLOT: begin
                // The bag memory reads the slot address by default.
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_status.repeat_hit) begin
                    o_cmd.swap_slot = 1'b1;
                    n_state         = S_RD_SLOT;
                end else begin
                    o_cmd.take_pick = 1'b1;
                    n_state         = S_WR;
                end
            end
            S_WR: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/shuffle_bag_index_picker.sv */
// A pool size of zero skips the refill, modulo and bag steps and goes to the result load.
// A draw from a filled bag runs the 32-step modulo unit, then slot read, check, bag update;
// the no-repeat fallback repeats the slot read and check, and a refill (first request,
// size change, empty bag) first writes every entry of the bag memory.
// Throughput: one request at a time; the next is taken the cycle after the result is loaded.
// Reset (i_rst_n low, synchronous) empties the bag, clears the stored pool size and last pick.
// ============================================================================
// shuffle_bag_index_picker
// Draws indices 0..size-1 without replacement from a single refilling bag.
// ============================================================================
module shuffle_bag_index_picker
    import sbip_pkg::*;
#(
    parameter int unsigned POOL_MAX = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [8:0] pool_size, [40:9] random_word, rest zero
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] picked_index
    output logic [0:0]  m_axis_tuser    // [0] empty_pool_error
);

    t_cmd    cmd;
    t_status status;
    logic    err;

    // The controller walks each item through its steps: capture, optional refill of the
    // bag memory one entry a cycle, a bit-serial modulo reduction, slot read with the
    // no-repeat check, bag update, and finally the load of the output register.
    sbip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the bag memory and all per-item and per-bag registers.
    sbip_dp #(
        .POOL_MAX (POOL_MAX)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_pool_size        (s_axis_tdata[8:0]),
        .i_random_word      (s_axis_tdata[40:9]),
        .o_picked_index     (m_axis_tdata),
        .o_empty_pool_error (err)
    );

    assign m_axis_tuser = err;

endmodule

/* tb/sbip_pick_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// sbip_pick_checker
// Watches the request and result channels of the shuffle bag index picker,
// keeps its own copy of the bag and checks every result item in order.
// ============================================================================
module sbip_pick_checker
    import sbip_pkg::*;
#(
    parameter int unsigned PoolMax = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [47:0] i_req_data,   // [8:0] pool_size, [40:9] random_word, rest zero
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [7:0]  i_res_data,   // [7:0] picked_index
    input  logic [0:0]  i_res_user,   // [0] empty_pool_error
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_checked,
    output int unsigned o_refills,
    output int unsigned o_swaps
);

    localparam int unsigned ReportMax = 10;

    typedef struct packed {
        logic [IndexW-1:0] index;
        logic              empty_err;
    } t_pick;

    logic [IndexW-1:0] bag [PoolMax];
    logic [SizeW-1:0]  bag_count;
    logic [SizeW-1:0]  pool_now;
    logic [IndexW-1:0] last_pick;
    logic              last_pick_valid;
    t_pick             expected_picks [$];

    int unsigned mismatch_count = 0;
    int unsigned checked_count  = 0;
    int unsigned refill_count   = 0;
    int unsigned swap_count     = 0;

    assign o_checked = checked_count;
    assign o_refills = refill_count;
    assign o_swaps   = swap_count;

    // Advances the private bag by one request and returns the item it should give.
    function automatic t_pick draw_from_bag(input logic [SizeW-1:0] req_size,
                                            input logic [WordW-1:0] word);
        t_pick            res;
        logic [SizeW-1:0] size;
        int unsigned      slot;
        int unsigned      count;
        res = '0;
        if (req_size == '0) begin
            // An empty pool leaves the bag untouched.
            res.empty_err = 1'b1;
            return res;
        end
        size = (req_size > PoolMax) ? SizeW'(PoolMax) : req_size;
        if (size != pool_now) begin
            bag_count       = '0;
            last_pick_valid = 1'b0;
            pool_now        = size;
        end
        if (bag_count == '0) begin
            for (int i = 0; i < int'(size); i++) bag[i] = IndexW'(i);
            bag_count = size;
            refill_count++;
        end
        count = bag_count;
        slot  = int'(word % count);
        // A fresh bag must not hand out the index that was drawn just before it.
        if (size > 1 && bag_count == size && last_pick_valid && bag[slot] == last_pick) begin
            slot = (slot == 0) ? 1 : 0;
            swap_count++;
        end
        res.index       = bag[slot];
        bag[slot]       = bag[count - 1];
        bag_count       = bag_count - 1'b1;
        last_pick       = res.index;
        last_pick_valid = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pick got;
        t_pick want;
        if (!i_rst_n) begin
            expected_picks.delete();
            bag_count       = '0;
            pool_now        = '0;
            last_pick       = '0;
            last_pick_valid = 1'b0;
        end else begin
            // The result is taken before a request on the same edge is predicted.
            if (i_res_valid && i_res_ready) begin
                got.index     = i_res_data;
                got.empty_err = i_res_user[0];
                if (expected_picks.size() == 0) begin
                    if (mismatch_count < ReportMax)
                        $display("%0t: result item with none expected: index %0d, error %0b",
                                 $realtime, got.index, got.empty_err);
                    mismatch_count++;
                end else begin
                    want = expected_picks.pop_front();
                    checked_count++;
                    if (got.index != want.index || got.empty_err != want.empty_err) begin
                        if (mismatch_count < ReportMax)
                            $display({"%0t: mismatch: index %0d (expected %0d), ",
                                      "error %0b (expected %0b)"},
                                     $realtime, got.index, want.index,
                                     got.empty_err, want.empty_err);
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_picks.insert(expected_picks.size(),
                                      draw_from_bag(i_req_data[SizeW-1:0],
                                                    i_req_data[SizeW+WordW-1:SizeW]));
        end
        o_pending    <= expected_picks.size();
        o_fail_count <= mismatch_count;
    end

endmodule

/* tb/shuffle_bag_index_picker_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// shuffle_bag_index_picker_tb
// Drives draw requests into the shuffle bag index picker and lets a checker
// compare every result item with its own bag; random stalls on both sides.
// ============================================================================
module shuffle_bag_index_picker_tb;
    import sbip_pkg::*;

    localparam int unsigned PoolMax     = 256;
    localparam int unsigned RandomItems = 450;
    localparam int unsigned IdlePct     = 34;
    // The slowest item refills 256 entries before its draw; the limit is set
    // to cover that worst case for every item of the run, with stalls on
    // both sides.
    localparam int unsigned CycleLimit  = 1000000;
    localparam int unsigned DrainCycles = 300;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // [8:0] pool_size, [40:9] random_word, rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] picked_index
    logic [0:0]  m_axis_tuser;         // [0] empty_pool_error

    // While calm is high neither side idles.
    logic        calm          = 1'b0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned refills;
    int unsigned swaps;
    int unsigned cycle_count   = 0;
    int unsigned sent_count    = 0;
    int unsigned empty_count   = 0;

    shuffle_bag_index_picker #(
        .POOL_MAX(PoolMax)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sbip_pick_checker #(
        .PoolMax(PoolMax)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_refills    (refills),
        .o_swaps      (swaps)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The result side stalls at random, except during the calm stretch.
    always @(posedge i_clk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IdlePct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Timeout after %0d cycles with %0d result items outstanding.",
                     cycle_count, pending);
            $display("[shuffle_bag_index_picker] ERROR");
            $finish;
        end
    end

    // Presents one request and returns on the edge at which it is taken.
    // The valid is only lowered when a gap is inserted, so back-to-back items
    // keep it high without a second assignment in the same step.
    task automatic send_request(input logic [SizeW-1:0] size, input logic [WordW-1:0] word);
        while (!calm && $urandom_range(99) < IdlePct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, word, size};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        if (size == '0) empty_count++;
    endtask

    // Holds the request side quiet until every predicted item has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly full-range words; some near zero and some near the top, so the
    // slot often lands on the first or last bag entry.
    function automatic logic [WordW-1:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom;
        if (roll < 85) return WordW'($urandom_range(0, 7));
        return {WordW{1'b1}} - WordW'($urandom_range(0, 7));
    endfunction

    initial begin
        int unsigned random_sent;
        int unsigned roll;
        int unsigned base;
        int unsigned run_len;
        logic [SizeW-1:0] size;
        random_sent = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------------------------------------------------------------
        // Directed part.
        // ---------------------------------------------------------------------
        // Empty pool before any draw; a second one follows the pool of one, so the word is tried at both extremes.
        send_request(9'd0, 32'h0000_0000);
        // A pool of one always answers zero, however large the word.
        send_request(9'd1, 32'hFFFF_FFFF);
        send_request(9'd1, 32'h0000_0000);
        send_request(9'd0, 32'hFFFF_FFFF);
        // Pool of two: draw 0 then 1; after the refill slot 1 holds the last
        // pick, so the block must fall back to slot 0.
        send_request(9'd2, 32'd0);
        send_request(9'd2, 32'd0);
        send_request(9'd2, 32'd1);
        send_request(9'd2, 32'd0);
        // Pool of three drained as 2, 1, 0 with an empty-pool request in the
        // middle that must not disturb the bag. The refill then sees slot 0
        // holding the last pick, so slot 1 is used instead.
        send_request(9'd3, 32'd2);
        send_request(9'd0, 32'h1234_5678);
        send_request(9'd3, 32'd1);
        send_request(9'd3, 32'd0);
        send_request(9'd3, 32'd0);
        // Largest pool, then sizes above it that saturate to the same pool and
        // so must not restart the bag.
        send_request(9'd256, 32'hFFFF_FFFF);
        send_request(9'd256, 32'h0000_0000);
        send_request(9'd256, 32'h8000_0000);
        send_request(9'd257, 32'h5555_5555);
        send_request(9'd511, 32'hAAAA_AAAA);
        send_request(9'd256, 32'd1);
        // Size change right after the largest pool.
        send_request(9'd255, 32'hFFFF_FFFE);
        send_request(9'd255, 32'd254);

        // Let everything come back before the random part starts.
        wait_drained();

        // ---------------------------------------------------------------------
        // Random part: runs of one pool size; a small pool's run can be long
        // enough to empty the bag and refill it, so the no-repeat rule is hit
        // often. A few empty-pool requests are scattered inside the runs.
        // ---------------------------------------------------------------------
        while (random_sent < RandomItems) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                base    = $urandom_range(1, 8);
                run_len = $urandom_range(1, 3 * base + 2);
            end else if (roll < 85) begin
                base    = $urandom_range(9, 40);
                run_len = $urandom_range(1, 2 * base);
            end else if (roll < 93) begin
                base    = $urandom_range(41, 255);
                run_len = $urandom_range(1, 10);
            end else begin
                base    = PoolMax;
                run_len = $urandom_range(1, 10);
            end
            for (int k = 0; k < int'(run_len) && random_sent < RandomItems; k++) begin
                if ($urandom_range(99) < 5)
                    size = '0;
                else if (base == PoolMax)
                    size = SizeW'($urandom_range(PoolMax, 511));
                else
                    size = SizeW'(base);
                send_request(size, pick_word());
                random_sent++;
                calm <= (random_sent >= 150 && random_sent < 260);
                if (random_sent == RandomItems / 2)
                    wait_drained();
            end
        end

        // Drain, then give the block time to show any stray result item.
        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);

        $display("Issued %0d requests (%0d with an empty pool); %0d result items compared.",
                 sent_count, empty_count, checked);
        $display("The bag was refilled %0d times and the no-repeat fallback was taken %0d times.",
                 refills, swaps);
        if (fail_count == 0 && pending == 0) begin
            $display("[shuffle_bag_index_picker] OK");
        end else begin
            $display("%0d mismatches, %0d result items never arrived.", fail_count, pending);
            $display("[shuffle_bag_index_picker] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sbip_pkg.sv
rtl/sbip_ram.sv
rtl/sbip_dp.sv
rtl/sbip_ctrl.sv
rtl/shuffle_bag_index_picker.sv
tb/sbip_pick_checker.sv
tb/shuffle_bag_index_picker_tb.sv
